// ----- hdl/ssk_pkg.sv -----
// Shared constants, request/response structs and helper functions of the spreader sketch.
package ssk_pkg;

  localparam int unsigned RegCount   = 65536;
  localparam int unsigned RegAw      = 16;
  localparam int unsigned TabEntries = 256;
  localparam int unsigned TabAw      = 8;
  localparam int unsigned QW         = 41;
  localparam int unsigned DivNw      = 57;
  localparam int unsigned DivDw      = 41;

  localparam logic [31:0] SeedInit = 32'd51318471;
  localparam logic [31:0] SeedStep = 32'd15417891;
  localparam logic [4:0]  RankCap  = 5'h1F;
  localparam logic [QW-1:0] QOne   = QW'(1) << 40;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdRead   = 1'b1;

  localparam logic CfgRegsInUse = 1'b0;
  localparam logic CfgSeed      = 1'b1;

  localparam logic [31:0] MurC1   = 32'hcc9e2d51;
  localparam logic [31:0] MurC2   = 32'h1b873593;
  localparam logic [31:0] MurAdd  = 32'he6546b64;
  localparam logic [31:0] MurF1   = 32'h85ebca6b;
  localparam logic [31:0] MurF2   = 32'hc2b2ae35;
  localparam logic [31:0] MurLen  = 32'd8;
  localparam logic [31:0] MurFive = 32'd5;

  typedef struct packed {
    logic        start;
    logic [31:0] seed;
    logic [31:0] key_a;
    logic [31:0] key_b;
  } hash_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } hash_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DivNw-1:0] num;
    logic [DivDw-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivNw-1:0] quot;
    logic [DivDw-1:0] rem;
  } div_rsp_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

  // leading zeros plus one, capped; an all-zero hash gives the cap
  function automatic logic [4:0] rank_of(input logic [31:0] h);
    logic [4:0] r;
    logic       hit;
    r   = RankCap;
    hit = 1'b0;
    for (int i = 0; i < 31; i++) begin
      if (!hit && h[31-i]) begin
        r   = 5'(i + 1);
        hit = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ----- hdl/ssk_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ssk_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- hdl/ssk_hash.sv -----
// Eight-step MurmurHash3 unit for an 8-byte key around one shared 32-bit multiplier.
module ssk_hash (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssk_pkg::hash_req_t req_i,
  output ssk_pkg::hash_rsp_t rsp_o
);

  logic        busy_q;
  logic        done_q;
  logic [2:0]  step_q;
  logic [31:0] acc_q;
  logic [31:0] h_q;
  logic [31:0] keyb_q;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] add_c;
  logic [31:0] res;
  logic [31:0] t1;
  logic        to_acc;

  always_comb begin
    mul_a  = acc_q;
    mul_b  = ssk_pkg::MurC1;
    add_c  = '0;
    to_acc = 1'b1;
    t1     = h_q ^ ssk_pkg::MurLen;
    case (step_q)
      3'd0: begin
        mul_a = acc_q;
      end
      3'd1: begin
        mul_a = ssk_pkg::rotl32(acc_q, 15);
        mul_b = ssk_pkg::MurC2;
      end
      3'd2: begin
        mul_a  = ssk_pkg::rotl32(h_q ^ acc_q, 13);
        mul_b  = ssk_pkg::MurFive;
        add_c  = ssk_pkg::MurAdd;
        to_acc = 1'b0;
      end
      3'd3: begin
        mul_a = keyb_q;
      end
      3'd4: begin
        mul_a = ssk_pkg::rotl32(acc_q, 15);
        mul_b = ssk_pkg::MurC2;
      end
      3'd5: begin
        mul_a  = ssk_pkg::rotl32(h_q ^ acc_q, 13);
        mul_b  = ssk_pkg::MurFive;
        add_c  = ssk_pkg::MurAdd;
        to_acc = 1'b0;
      end
      3'd6: begin
        mul_a  = t1 ^ (t1 >> 16);
        mul_b  = ssk_pkg::MurF1;
        to_acc = 1'b0;
      end
      default: begin
        mul_a  = h_q ^ (h_q >> 13);
        mul_b  = ssk_pkg::MurF2;
        to_acc = 1'b0;
      end
    endcase
    res = mul_a * mul_b + add_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd7) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q  <= req_i.key_a;
      keyb_q <= req_i.key_b;
      h_q    <= req_i.seed;
    end else if (busy_q) begin
      if (to_acc) begin
        acc_q <= res;
      end else begin
        h_q <= res;
      end
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = h_q ^ (h_q >> 16);

endmodule

// ----- hdl/ssk_div.sv -----
// Restoring divider, one quotient bit per cycle.
module ssk_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssk_pkg::div_req_t req_i,
  output ssk_pkg::div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(ssk_pkg::DivNw);

  logic                      busy_q;
  logic                      done_q;
  logic [CntW-1:0]           cnt_q;
  logic [ssk_pkg::DivNw-1:0] num_q;
  logic [ssk_pkg::DivDw-1:0] rem_q;
  logic [ssk_pkg::DivDw-1:0] den_q;
  logic [ssk_pkg::DivDw:0]   shifted;
  logic [ssk_pkg::DivDw+1:0] diff;
  logic                      ge;

  always_comb begin
    shifted = {rem_q, num_q[ssk_pkg::DivNw-1]};
    diff    = {1'b0, shifted} - {2'b00, den_q};
    ge      = ~diff[ssk_pkg::DivDw+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(ssk_pkg::DivNw - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[ssk_pkg::DivNw-2:0], ge};
      rem_q <= ge ? diff[ssk_pkg::DivDw-1:0] : shifted[ssk_pkg::DivDw-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ----- hdl/super_spreader_sketch_top.sv -----
// Spreader sketch top level: rank-register sketch, sequencer and top-k table.
// Insert that raises no register: two hashes, the index modulo, a rank register read and a compare.
// Insert that raises a register: also one or two more divisions and a scan of the whole table.
// Table read: one read of the entry, skipped when the entry is not valid. One item at a time.
// Reset: asynchronous, active low; then a clearing pass over all the rank registers
// runs before the first item is taken (configuration writes are taken meanwhile).
module super_spreader_sketch_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  // source_key[31:0], destination[63:32], random_round[79:64], random_replace[95:80],
  // entry_index[103:96]
  input  logic [103:0] s_tdata_i,
  // command[0]
  input  logic [0:0]   s_tuser_i,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // flow_key[31:0], flow_estimate[63:32], flow_error[95:64]
  output logic [95:0]  m_tdata_o,
  // register_raised[0], entry_valid[1]
  output logic [1:0]   m_tuser_o,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  typedef enum logic [14:0] {
    S_CLEAR = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_HASH1 = 15'b000000000000100,
    S_HASH2 = 15'b000000000001000,
    S_MOD   = 15'b000000000010000,
    S_RRD   = 15'b000000000100000,
    S_DEC   = 15'b000000001000000,
    S_DIVI  = 15'b000000010000000,
    S_DIVQ  = 15'b000000100000000,
    S_SCAN  = 15'b000001000000000,
    S_PICK  = 15'b000010000000000,
    S_WRITE = 15'b000100000000000,
    S_RENT  = 15'b001000000000000,
    S_RDAT  = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_e;

  localparam int unsigned RegAw = ssk_pkg::RegAw;
  localparam int unsigned TabAw = ssk_pkg::TabAw;
  localparam int unsigned QW    = ssk_pkg::QW;

  state_e state_q, state_d;

  logic [16:0]    regs_in_use_q;
  logic [31:0]    seed_q;
  logic [QW-1:0]  q_q;
  logic [31:0]    src_q, dst_q, h1_q, inc_q;
  logic [15:0]    rr_q, rp_q;
  logic [TabAw-1:0] idx_q, pick_q, fidx_q, freeidx_q, minidx_q;
  logic [RegAw-1:0] reg_idx_q, clr_q;
  logic [4:0]     rank_q, old_q;
  logic [TabAw:0] scan_q;
  logic           found_q, free_q;
  logic [31:0]    fctr_q, ferr_q, min_q, minkey_q, minerr_q;
  logic [ssk_pkg::TabEntries-1:0] valid_q;
  logic           setv_q;
  logic [31:0]    wkey_q, wctr_q, werr_q;
  logic           res_raised_q, res_valid_q;
  logic [31:0]    res_key_q, res_est_q, res_err_q;
  logic           out_valid_q, out_raised_q, out_evalid_q;
  logic [31:0]    out_key_q, out_est_q, out_err_q;

  logic accept, out_load, raise;
  logic [16:0]   m_eff;
  logic [4:0]    old_sel;
  logic [QW-1:0] d_val;
  logic [4:0]    rank_rd;
  logic [31:0]   key_rd, ctr_rd, err_rd;
  logic [TabAw-1:0] entry;
  logic [TabAw-1:0] tab_raddr;
  logic rank_we;
  logic [RegAw-1:0] rank_waddr;
  logic [4:0]    rank_wdata;
  logic [47:0]   inc_sat;
  logic [31:0]   inc_new;
  logic [31:0]   nv;
  logic [47:0]   repl_lhs;
  logic          repl;
  logic [QW-1:0] delta;

  ssk_pkg::hash_req_t hash_req;
  ssk_pkg::hash_rsp_t hash_rsp;
  ssk_pkg::div_req_t  div_req;
  ssk_pkg::div_rsp_t  div_rsp;

  assign s_tready_o = (state_q == S_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || m_tready_i);

  always_comb begin
    if (regs_in_use_q == 17'd0) begin
      m_eff = 17'd1;
    end else if (regs_in_use_q > 17'(ssk_pkg::RegCount)) begin
      m_eff = 17'(ssk_pkg::RegCount);
    end else begin
      m_eff = regs_in_use_q;
    end
  end

  assign raise   = rank_q > rank_rd;
  assign old_sel = (state_q == S_DEC) ? rank_rd : old_q;
  always_comb begin
    d_val = QW'(1) << (6'd40 - {1'b0, old_sel});
    if (rank_q != ssk_pkg::RankCap) begin
      d_val = d_val - (QW'(1) << (6'd40 - {1'b0, rank_q}));
    end
  end

  // hash unit: first seed on accepting an insert, second seed when the first is done
  always_comb begin
    hash_req.start = (accept && s_tuser_i[0] == ssk_pkg::CmdInsert)
                   || (state_q == S_HASH1 && hash_rsp.done);
    hash_req.seed  = (state_q == S_HASH1) ? seed_q + ssk_pkg::SeedStep : seed_q;
    hash_req.key_a = (state_q == S_IDLE) ? s_tdata_i[31:0] : src_q;
    hash_req.key_b = (state_q == S_IDLE) ? s_tdata_i[63:32] : dst_q;
  end

  // divider: index modulo, then increment (only when q is not zero), then drop of q
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = {25'd0, h1_q};
    div_req.den   = {24'd0, m_eff};
    case (state_q)
      S_HASH2: begin
        div_req.start = hash_rsp.done;
      end
      S_DEC: begin
        div_req.start = raise;
        if (q_q != '0) begin
          div_req.num = ssk_pkg::DivNw'(1) << 56;
          div_req.den = q_q;
        end else begin
          div_req.num = {16'd0, d_val};
        end
      end
      S_DIVI: begin
        div_req.start = div_rsp.done;
        div_req.num   = {16'd0, d_val};
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  ssk_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hash_req),
    .rsp_o  (hash_rsp)
  );

  ssk_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign rank_we    = (state_q == S_CLEAR) || (state_q == S_DEC && raise);
  assign rank_waddr = (state_q == S_CLEAR) ? clr_q : reg_idx_q;
  assign rank_wdata = (state_q == S_CLEAR) ? 5'd0 : rank_q;

  ssk_ram #(.Width(5), .Depth(ssk_pkg::RegCount)) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (rank_waddr),
    .wdata_i (rank_wdata),
    .raddr_i (reg_idx_q),
    .rdata_o (rank_rd)
  );

  assign tab_raddr = (state_q == S_SCAN) ? scan_q[TabAw-1:0] : idx_q;

  ssk_ram #(.Width(32), .Depth(ssk_pkg::TabEntries)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == S_WRITE),
    .waddr_i (pick_q),
    .wdata_i (wkey_q),
    .raddr_i (tab_raddr),
    .rdata_o (key_rd)
  );

  ssk_ram #(.Width(32), .Depth(ssk_pkg::TabEntries)) u_ctr_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == S_WRITE),
    .waddr_i (pick_q),
    .wdata_i (wctr_q),
    .raddr_i (tab_raddr),
    .rdata_o (ctr_rd)
  );

  ssk_ram #(.Width(32), .Depth(ssk_pkg::TabEntries)) u_err_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == S_WRITE),
    .waddr_i (pick_q),
    .wdata_i (werr_q),
    .raddr_i (tab_raddr),
    .rdata_o (err_rd)
  );

  // increment from q, rounded with the random fraction
  always_comb begin
    inc_sat = (|div_rsp.quot[56:48]) ? 48'hFFFF_FFFF_FFFF : div_rsp.quot[47:0];
    inc_new = inc_sat[47:16];
    if (rr_q < inc_sat[15:0]) begin
      inc_new = ssk_pkg::sat_add32(inc_sat[47:16], 32'd1);
    end
  end

  assign delta    = div_rsp.quot[QW-1:0];
  assign entry    = scan_q[TabAw-1:0] - TabAw'(1);
  assign nv       = ssk_pkg::sat_add32(min_q, inc_q);
  assign repl_lhs = rp_q * nv;
  assign repl     = repl_lhs < {inc_q, 16'd0};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == '1) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (s_tuser_i[0] == ssk_pkg::CmdRead) begin
            state_d = valid_q[s_tdata_i[103:96]] ? S_RENT : S_OUT;
          end else begin
            state_d = S_HASH1;
          end
        end
      end
      S_HASH1: if (hash_rsp.done) state_d = S_HASH2;
      S_HASH2: if (hash_rsp.done) state_d = S_MOD;
      S_MOD:   if (div_rsp.done) state_d = S_RRD;
      S_RRD:   state_d = S_DEC;
      S_DEC: begin
        if (!raise) begin
          state_d = S_OUT;
        end else begin
          state_d = (q_q != '0) ? S_DIVI : S_DIVQ;
        end
      end
      S_DIVI:  if (div_rsp.done) state_d = S_DIVQ;
      S_DIVQ:  if (div_rsp.done) state_d = S_SCAN;
      S_SCAN:  if (scan_q == (TabAw+1)'(ssk_pkg::TabEntries)) state_d = S_PICK;
      S_PICK:  state_d = S_WRITE;
      S_WRITE: state_d = S_OUT;
      S_RENT:  state_d = S_RDAT;
      S_RDAT:  state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_q         <= '0;
      regs_in_use_q <= 17'(ssk_pkg::RegCount);
      seed_q        <= ssk_pkg::SeedInit;
      q_q           <= ssk_pkg::QOne;
      valid_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + RegAw'(1);
      end
      if (cfg_we_i) begin
        if (cfg_idx_i[0] == ssk_pkg::CfgRegsInUse) begin
          regs_in_use_q <= cfg_data_i[16:0];
        end else begin
          seed_q <= cfg_data_i;
        end
      end
      if (state_q == S_DIVQ && div_rsp.done) begin
        q_q <= (q_q > delta) ? q_q - delta : '0;
      end
      if (state_q == S_WRITE && setv_q) begin
        valid_q[pick_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q <= s_tdata_i[31:0];
      dst_q <= s_tdata_i[63:32];
      rr_q  <= s_tdata_i[79:64];
      rp_q  <= s_tdata_i[95:80];
      idx_q <= s_tdata_i[103:96];
      res_raised_q <= 1'b0;
      res_valid_q  <= 1'b0;
      res_key_q    <= '0;
      res_est_q    <= '0;
      res_err_q    <= '0;
    end
    if (state_q == S_HASH1 && hash_rsp.done) begin
      h1_q <= hash_rsp.value;
    end
    if (state_q == S_HASH2 && hash_rsp.done) begin
      rank_q <= ssk_pkg::rank_of(hash_rsp.value);
    end
    if (state_q == S_MOD && div_rsp.done) begin
      reg_idx_q <= div_rsp.rem[RegAw-1:0];
    end
    if (state_q == S_DEC) begin
      old_q <= rank_rd;
      inc_q <= 32'hFFFF_FFFF;
    end
    if (state_q == S_DIVI && div_rsp.done) begin
      inc_q <= inc_new;
    end
    if (state_q == S_DIVQ) begin
      scan_q  <= '0;
      found_q <= 1'b0;
      free_q  <= 1'b0;
    end
    if (state_q == S_SCAN) begin
      scan_q <= scan_q + (TabAw+1)'(1);
      if (scan_q != '0) begin
        if (valid_q[entry] && key_rd == src_q && !found_q) begin
          found_q <= 1'b1;
          fidx_q  <= entry;
          fctr_q  <= ctr_rd;
          ferr_q  <= err_rd;
        end
        if (!valid_q[entry] && !free_q) begin
          free_q    <= 1'b1;
          freeidx_q <= entry;
        end
        // strict compare keeps the lowest index among equal minima
        if (scan_q == (TabAw+1)'(1) || ctr_rd < min_q) begin
          min_q    <= ctr_rd;
          minidx_q <= entry;
          minkey_q <= key_rd;
          minerr_q <= err_rd;
        end
      end
    end
    if (state_q == S_PICK) begin
      if (found_q) begin
        pick_q <= fidx_q;
        wkey_q <= src_q;
        wctr_q <= ssk_pkg::sat_add32(fctr_q, inc_q);
        werr_q <= ferr_q;
        setv_q <= 1'b0;
      end else if (free_q) begin
        pick_q <= freeidx_q;
        wkey_q <= src_q;
        wctr_q <= inc_q;
        werr_q <= '0;
        setv_q <= 1'b1;
      end else begin
        pick_q <= minidx_q;
        wkey_q <= repl ? src_q : minkey_q;
        wctr_q <= nv;
        werr_q <= repl ? min_q : minerr_q;
        setv_q <= 1'b0;
      end
    end
    if (state_q == S_WRITE) begin
      res_raised_q <= 1'b1;
      res_valid_q  <= 1'b1;
      res_key_q    <= wkey_q;
      res_est_q    <= wctr_q;
      res_err_q    <= werr_q;
    end
    if (state_q == S_RDAT) begin
      res_valid_q <= 1'b1;
      res_key_q   <= key_rd;
      res_est_q   <= ctr_rd;
      res_err_q   <= err_rd;
    end
    if (out_load) begin
      out_raised_q <= res_raised_q;
      out_evalid_q <= res_valid_q;
      out_key_q    <= res_key_q;
      out_est_q    <= res_est_q;
      out_err_q    <= res_err_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {out_err_q, out_est_q, out_key_q};
  assign m_tuser_o  = {out_evalid_q, out_raised_q};

  a_q_never_rises: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_q <= $past(q_q))
    else $error("update probability rose");

  a_raise_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o[0] |-> m_tuser_o[1])
    else $error("raised result without valid entry");

  a_clear_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !s_tready_o)
    else $error("item taken during clearing pass");

  a_hash_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_rsp.done |-> (state_q == S_HASH1 || state_q == S_HASH2))
    else $error("hash result outside hash phase");

endmodule

// ----- bench/super_spreader_sketch_top_tb.sv -----
// Self-checking bench for the spreader sketch: directed table, then random phases against a predictor.
module super_spreader_sketch_top_tb;

  typedef struct {
    logic        raised;
    logic [31:0] key;
    logic [31:0] estimate;
    logic [31:0] err_bound;
    logic        valid;
  } flow_rsp_t;

  typedef struct {
    logic        cmd;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] rnd_round;
    logic [15:0] rnd_replace;
    logic [7:0]  idx;
    bit          typed;
    flow_rsp_t   rsp;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b1;
  logic         s_tvalid_i = 1'b0;
  logic         s_tready_o;
  logic [103:0] s_tdata_i = '0;
  logic [0:0]   s_tuser_i = '0;
  logic         m_tvalid_o;
  logic         m_tready_i = 1'b0;
  logic [95:0]  m_tdata_o;
  logic [1:0]   m_tuser_o;
  logic         cfg_we_i = 1'b0;
  logic [0:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;

  super_spreader_sketch_top i_dut (.*);

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [4:0]  rank_regs [ssk_pkg::RegCount];
  logic [40:0] upd_prob;
  logic [31:0] tab_key [ssk_pkg::TabEntries];
  logic [31:0] tab_cnt [ssk_pkg::TabEntries];
  logic [31:0] tab_err [ssk_pkg::TabEntries];
  bit          tab_vld [ssk_pkg::TabEntries];
  int unsigned tab_occ;
  logic [16:0] regs_in_use;
  logic [31:0] seed_cfg;

  flow_rsp_t   pending_rsp[$];
  int unsigned n_mismatch, n_inserts, n_raises, n_reads, n_full_updates;
  int unsigned stall_pct;

  function automatic logic [31:0] rot(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] mix(input logic [31:0] h, input logic [31:0] k);
    k = k * 32'hcc9e2d51;
    k = rot(k, 15);
    k = k * 32'h1b873593;
    h = rot(h ^ k, 13);
    return h * 32'd5 + 32'he6546b64;
  endfunction

  function automatic logic [31:0] pair_hash(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] sd);
    logic [31:0] h;
    h = mix(mix(sd, a), b) ^ 32'd8;
    h = h ^ (h >> 16);
    h = h * 32'h85ebca6b;
    h = h ^ (h >> 13);
    h = h * 32'hc2b2ae35;
    return h ^ (h >> 16);
  endfunction

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic flow_rsp_t read_entry(input logic [7:0] idx);
    flow_rsp_t r;
    r = '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0};
    if (tab_vld[idx]) r = '{1'b0, tab_key[idx], tab_cnt[idx], tab_err[idx], 1'b1};
    return r;
  endfunction

  function automatic flow_rsp_t spread_update(input logic [31:0] src, input logic [31:0] dst,
                                              input logic [15:0] rr, input logic [15:0] rp);
    flow_rsp_t   r;
    longint unsigned m, inc, d, delta;
    logic [31:0] h1, h2, inc_int, minv, nv;
    int unsigned reg_i, rank, old, pick;
    int          found, free_slot;
    r = '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0};
    m = regs_in_use;
    if (m == 0) m = 1;
    if (m > ssk_pkg::RegCount) m = ssk_pkg::RegCount;
    h1 = pair_hash(src, dst, seed_cfg);
    h2 = pair_hash(src, dst, seed_cfg + 32'd15417891);
    reg_i = h1 % m;
    rank = 1;
    while (rank < 31 && !h2[31]) begin
      h2 = h2 << 1;
      rank++;
    end
    old = rank_regs[reg_i];
    if (rank <= old) return r;
    if (upd_prob == 0) begin
      inc_int = 32'hFFFF_FFFF;
    end else begin
      inc = (64'd1 << 56) / upd_prob;
      if (inc > 64'hFFFF_FFFF_FFFF) inc = 64'hFFFF_FFFF_FFFF;
      inc_int = inc[47:16];
      if (rr < inc[15:0]) inc_int = add_sat(inc_int, 32'd1);
    end
    d = 64'd1 << (40 - old);
    if (rank != 31) d = d - (64'd1 << (40 - rank));
    delta = d / m;
    upd_prob = (upd_prob > delta) ? upd_prob - 41'(delta) : '0;
    rank_regs[reg_i] = 5'(rank);
    n_raises++;
    found = -1;
    free_slot = -1;
    for (int i = 0; i < ssk_pkg::TabEntries; i++) begin
      if (tab_vld[i]) begin
        if (found < 0 && tab_key[i] == src) found = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (found >= 0) begin
      pick = found;
      tab_cnt[pick] = add_sat(tab_cnt[pick], inc_int);
    end else if (tab_occ < ssk_pkg::TabEntries && free_slot >= 0) begin
      pick = free_slot;
      tab_key[pick] = src;
      tab_cnt[pick] = inc_int;
      tab_err[pick] = '0;
      tab_vld[pick] = 1'b1;
      tab_occ++;
    end else begin
      // full table: lowest counter, ties to the lowest index
      n_full_updates++;
      pick = 0;
      for (int i = 1; i < ssk_pkg::TabEntries; i++) if (tab_cnt[i] < tab_cnt[pick]) pick = i;
      minv = tab_cnt[pick];
      nv = add_sat(minv, inc_int);
      if (64'(rp) * 64'(nv) < (64'(inc_int) << 16)) begin
        tab_key[pick] = src;
        tab_err[pick] = minv;
      end
      tab_cnt[pick] = nv;
    end
    r = read_entry(8'(pick));
    r.raised = 1'b1;
    return r;
  endfunction

  // result side: random stall and in-order check
  always @(posedge clk_i) begin
    flow_rsp_t e;
    flow_rsp_t got;
    m_tready_i <= ($urandom_range(99) >= stall_pct);
    if (m_tvalid_o && m_tready_i) begin
      got = '{m_tuser_o[0], m_tdata_o[31:0], m_tdata_o[63:32], m_tdata_o[95:64], m_tuser_o[1]};
      if (pending_rsp.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected item: %p", got);
      end else begin
        e = pending_rsp.pop_front();
        if (got.raised !== e.raised || got.key !== e.key || got.estimate !== e.estimate ||
            got.err_bound !== e.err_bound || got.valid !== e.valid) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("mismatch: expected %p, got %p", e, got);
        end
      end
    end
  end

  task automatic write_cfg(input logic idx, input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ssk_pkg::CfgRegsInUse) regs_in_use = val[16:0];
    else seed_cfg = val;
  endtask

  task automatic drain;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic send_item(input stim_row_t row, input int unsigned idle_pct);
    flow_rsp_t e;
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= row.cmd;
    s_tdata_i  <= {row.idx, row.rnd_replace, row.rnd_round, row.dst, row.src};
    do @(posedge clk_i); while (!s_tready_o);
    if (row.cmd == ssk_pkg::CmdRead) begin
      n_reads++;
      e = row.typed ? row.rsp : read_entry(row.idx);
    end else begin
      n_inserts++;
      e = spread_update(row.src, row.dst, row.rnd_round, row.rnd_replace);
    end
    pending_rsp = {pending_rsp, e};
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic random_phase(input int unsigned items, input int unsigned idle_pct,
                              input int unsigned fresh_pct);
    stim_row_t row;
    for (int n = 0; n < items; n++) begin
      row.cmd = ($urandom_range(7) == 0) ? ssk_pkg::CmdRead : ssk_pkg::CmdInsert;
      row.src = ($urandom_range(99) < fresh_pct) ? $urandom() : 32'(32'hA500_0000 + $urandom_range(7));
      row.dst = $urandom();
      row.rnd_round = 16'($urandom());
      row.rnd_replace = 16'($urandom());
      row.idx = 8'($urandom());
      row.typed = 1'b0;
      send_item(row, idle_pct);
      // hold off once until the block has emptied
      if (n == items / 2 && idle_pct == 50) begin
        s_tvalid_i <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk_i);
      end
    end
    s_tvalid_i <= 1'b0;
  endtask

  localparam flow_rsp_t Empty = '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0};
  stim_row_t directed [12];

  initial begin
    rst_ni <= 1'b0;
    for (int i = 0; i < ssk_pkg::RegCount; i++) rank_regs[i] = '0;
    for (int i = 0; i < ssk_pkg::TabEntries; i++) begin
      tab_key[i] = '0; tab_cnt[i] = '0; tab_err[i] = '0; tab_vld[i] = 1'b0;
    end
    upd_prob = ssk_pkg::QOne;
    tab_occ = 0;
    regs_in_use = 17'd65536;
    seed_cfg = ssk_pkg::SeedInit;
    stall_pct = 0;
    directed = '{
      '{ssk_pkg::CmdRead,   32'h0,         32'h0,         16'h0,    16'h0,    8'd0,   1, Empty},
      '{ssk_pkg::CmdRead,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'd255, 1, Empty},
      '{ssk_pkg::CmdInsert, 32'h0,         32'h0,         16'h0,    16'h0,    8'd0,   0, Empty},
      '{ssk_pkg::CmdInsert, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'd255, 0, Empty},
      '{ssk_pkg::CmdInsert, 32'h0,         32'h1,         16'hFFFF, 16'h0,    8'd0,   0, Empty},
      '{ssk_pkg::CmdInsert, 32'hFFFF_FFFF, 32'h0,         16'h0,    16'hFFFF, 8'd0,   0, Empty},
      '{ssk_pkg::CmdRead,   32'h0,         32'h0,         16'h0,    16'h0,    8'd0,   0, Empty},
      '{ssk_pkg::CmdRead,   32'h0,         32'h0,         16'h0,    16'h0,    8'd1,   0, Empty},
      '{ssk_pkg::CmdRead,   32'h0,         32'h0,         16'h0,    16'h0,    8'd2,   1, Empty},
      '{ssk_pkg::CmdInsert, 32'h1234_5678, 32'h8765_4321, 16'h8000, 16'h8000, 8'd7,   0, Empty},
      '{ssk_pkg::CmdInsert, 32'h1234_5678, 32'h0BAD_F00D, 16'h0001, 16'h7FFF, 8'd128, 0, Empty},
      '{ssk_pkg::CmdRead,   32'h0,         32'h0,         16'h0,    16'h0,    8'd2,   0, Empty}
    };
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_cfg(ssk_pkg::CfgRegsInUse, 32'd65536);
    write_cfg(ssk_pkg::CfgSeed, ssk_pkg::SeedInit);
    foreach (directed[i]) send_item(directed[i], 0);
    s_tvalid_i <= 1'b0;
    drain();

    random_phase(190, 0, 90);
    drain();
    write_cfg(ssk_pkg::CfgRegsInUse, 32'h0001_FFFF);
    write_cfg(ssk_pkg::CfgSeed, 32'hFFFF_FFFF);
    random_phase(130, 50, 90);
    drain();
    stall_pct = 50;
    write_cfg(ssk_pkg::CfgRegsInUse, 32'(300 + $urandom_range(700)));
    write_cfg(ssk_pkg::CfgSeed, $urandom());
    random_phase(100, 0, 60);
    drain();
    stall_pct = 32;
    write_cfg(ssk_pkg::CfgRegsInUse, 32'd0);
    write_cfg(ssk_pkg::CfgSeed, 32'd0);
    random_phase(60, 32, 60);
    drain();
    write_cfg(ssk_pkg::CfgRegsInUse, 32'd1);

    $display("Covered %0d inserts (%0d raised a register, %0d on a full table), %0d reads,",
             n_inserts, n_raises, n_full_updates, n_reads);
    $display("over register counts 65536, above range, mid, zero, under four handshake loads.");
    if (n_mismatch == 0 && pending_rsp.size() == 0) begin
      $display("[super_spreader_sketch_top] OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", n_mismatch, pending_rsp.size());
      $display("[super_spreader_sketch_top] ERROR");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("timeout with %0d results outstanding", pending_rsp.size());
    $display("[super_spreader_sketch_top] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ssk_pkg.sv
hdl/ssk_ram.sv
hdl/ssk_hash.sv
hdl/ssk_div.sv
hdl/super_spreader_sketch_top.sv
bench/super_spreader_sketch_top_tb.sv
